// File: src/softened_point_mass_acceleration_core_macros.svh
// Assertion macros for the softened point mass acceleration core.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef SOFTENED_POINT_MASS_ACCELERATION_CORE_MACROS_SVH
`define SOFTENED_POINT_MASS_ACCELERATION_CORE_MACROS_SVH

// same-cycle implication
`define SPMA_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPMA_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/spma_pkg.sv
// Shared constants, register codes and the rsqrt seed table for the
// softened point mass acceleration core. No dependencies.
`default_nettype none

package spma_pkg;

   localparam int SPMA_COORD_WIDTH = 32;
   localparam int SPMA_FRAC_BITS   = 16;
   localparam int SPMA_A2_WIDTH    = 63;
   localparam int SPMA_MANT_W      = 32;
   localparam int SPMA_DATA_W      = 64;
   localparam int SPMA_ADDR_W      = 6;

   localparam logic [SPMA_A2_WIDTH-1:0] SPMA_A2_RESET = 63'h0000_0001_0000_0000;
   localparam logic [SPMA_MANT_W-1:0]   SPMA_THREE_Q30 = 32'hC000_0000;

   typedef enum logic [2:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_CENTER_Z = 3'd2,
      REG_SCALE_A2 = 3'd3,
      REG_NEG_GM   = 3'd4
   } csr_index_type;

   // seed for 1/sqrt(m), indexed by the top three mantissa bits (Q2.30)
   function automatic logic [SPMA_MANT_W-1:0] seed_lookup(input logic [2:0] idx);
      logic [SPMA_MANT_W-1:0] r;
      unique case (idx)
         3'd0: r = 32'd1073741824;
         3'd1: r = 32'd1073741824;
         3'd2: r = 32'd960383880;
         3'd3: r = 32'd811672535;
         3'd4: r = 32'd715827883;
         3'd5: r = 32'd647490681;
         3'd6: r = 32'd595604800;
         default: r = 32'd554477893;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/spma_if.sv
// Stream interfaces for position words in and acceleration words out.
// Depends on spma_pkg for default widths.
`default_nettype none

interface spma_req_if import spma_pkg::*; #(parameter int W = SPMA_COORD_WIDTH) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] pos_x;
   logic [W-1:0] pos_y;
   logic [W-1:0] pos_z;
   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface spma_rsp_if import spma_pkg::*; #(parameter int W = SPMA_COORD_WIDTH) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] acc_x;
   logic [W-1:0] acc_y;
   logic [W-1:0] acc_z;
   logic         saturated;
   modport source (output valid, acc_x, acc_y, acc_z, saturated, input ready);
   modport sink   (input valid, acc_x, acc_y, acc_z, saturated, output ready);
endinterface

`default_nettype wire

// File: src/spma_newton.sv
// One Newton step for 1/sqrt(m) in Q2.30, three register stages.
// Depends on spma_pkg; carries an opaque side word alongside.
`default_nettype none

module spma_newton import spma_pkg::*; #(
   parameter int SIDE_W = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [SPMA_MANT_W-1:0] in_y,
   input  wire logic [SPMA_MANT_W-1:0] in_m,
   input  wire logic [SIDE_W-1:0]      in_side,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [SPMA_MANT_W-1:0]      out_y,
   output logic [SPMA_MANT_W-1:0]      out_m,
   output logic [SIDE_W-1:0]           out_side
);

   logic                   va_ff, vb_ff, vc_ff;
   logic                   en_a, en_b, en_c;
   logic [SPMA_MANT_W-1:0] ya_ff, ma_ff, yb_ff, mb_ff, yc_ff, mc_ff;
   logic [SPMA_MANT_W+1:0] y2a_ff, y2a_in;
   logic [SPMA_MANT_W-1:0] diffb_ff, diffb_in, yc_in;
   logic [SIDE_W-1:0]      sa_ff, sb_ff, sc_ff;
   logic [63:0]            sq_a, prod_c;
   logic [65:0]            prod_b;
   logic [SPMA_MANT_W+1:0] t_b;

   assign en_c     = !vc_ff || out_ready;
   assign en_b     = !vb_ff || en_c;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   always_comb begin
      sq_a   = 64'(in_y) * 64'(in_y);
      y2a_in = sq_a[63:30];
      prod_b = 66'(ma_ff) * 66'(y2a_ff);
      t_b    = prod_b[63:30];
      // clamp t to 3.0 so the correction factor stays non-negative
      if (t_b > 34'(SPMA_THREE_Q30)) begin
         diffb_in = '0;
      end else begin
         diffb_in = SPMA_THREE_Q30 - t_b[SPMA_MANT_W-1:0];
      end
      prod_c = 64'(yb_ff) * 64'(diffb_ff);
      yc_in  = prod_c[62:31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (en_a) va_ff <= in_valid;
         if (en_b) vb_ff <= va_ff;
         if (en_c) vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         ya_ff  <= in_y;
         ma_ff  <= in_m;
         y2a_ff <= y2a_in;
         sa_ff  <= in_side;
      end
      if (en_b) begin
         yb_ff    <= ya_ff;
         mb_ff    <= ma_ff;
         diffb_ff <= diffb_in;
         sb_ff    <= sa_ff;
      end
      if (en_c) begin
         yc_ff <= yc_in;
         mc_ff <= mb_ff;
         sc_ff <= sb_ff;
      end
   end

   assign out_valid = vc_ff;
   assign out_y     = yc_ff;
   assign out_m     = mc_ff;
   assign out_side  = sc_ff;

endmodule

`default_nettype wire

// File: src/softened_point_mass_acceleration_core.sv
// Top level of the Plummer-softened point mass acceleration pipeline.
// Depends on spma_pkg, spma_if, spma_newton and the assertion macro header.
//
//   channel   dir  handshake        payload
//   req_chan  in   valid/ready      pos_x, pos_y, pos_z (signed Q.FRAC_BITS)
//   rsp_chan  out  valid/ready      acc_x, acc_y, acc_z, saturated
//   APB       in   psel/penable     5 registers at 8*i, 64-bit data
//
// One word enters per cycle while the output is not stalled; the pipeline has
// 6 front stages, three 3-stage Newton steps and 7 back stages.
// Every stage has its own valid bit and advances when it is empty or its
// successor advances, so bubbles close up and a stalled result holds in the
// output register while upstream stages keep filling.
// reset (synchronous) clears valid bits and the APB registers to their defaults.
`default_nettype none
`include "softened_point_mass_acceleration_core_macros.svh"

module softened_point_mass_acceleration_core import spma_pkg::*; #(
   parameter int COORD_WIDTH = SPMA_COORD_WIDTH,
   parameter int FRAC_BITS   = SPMA_FRAC_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   spma_req_if.sink                    req_chan,
   spma_rsp_if.source                  rsp_chan,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [SPMA_ADDR_W-1:0] paddr,
   input  wire logic [SPMA_DATA_W-1:0] pwdata,
   output logic [SPMA_DATA_W-1:0]      prdata,
   output logic                        pready
);

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;                      // offset magnitude
   localparam int SQW = 2 * DW;                      // squared offset
   localparam int SW  = ((SQW > SPMA_A2_WIDTH) ? SQW : SPMA_A2_WIDTH) + 2;
   localparam int BLW = $clog2(SW + 1);              // bit length of s
   localparam int LP  = (2 * FRAC_BITS > 30) ? 2 * FRAC_BITS - 30 : 0;
   localparam int SA_BASE = 27 - 2 * FRAC_BITS + LP;
   localparam int SA_MAX  = SA_BASE + 3 * ((SW + 1) / 2);
   localparam int SAW = $clog2(SA_MAX + 1);
   localparam int MW  = SPMA_MANT_W;
   localparam int PW  = CW + MW;                     // |neg_gm| * m^-1.5
   localparam int LOW = MW + DW;
   localparam int HIW = CW + DW;
   localparam int QW  = PW + DW;
   localparam int XW  = QW + LP;

   typedef struct packed {
      logic [2:0][DW-1:0] dm;    // offset magnitudes
      logic [2:0]         dn;    // offset signs
      logic               zero;  // r2 + a2 was zero
      logic [SAW-1:0]     sa;    // final right shift plus LP
   } side_type;

   localparam int SIDE_W = $bits(side_type);

   // ---------------------------------------------------------------- registers
   logic [CW-1:0]            cx_ff, cy_ff, cz_ff, gm_ff;
   logic [SPMA_A2_WIDTH-1:0] a2_ff;
   csr_index_type            csr_idx;
   logic                     csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[5:3]);
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         cz_ff <= '0;
         a2_ff <= SPMA_A2_RESET;
         gm_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_CENTER_X: cx_ff <= pwdata[CW-1:0];
            REG_CENTER_Y: cy_ff <= pwdata[CW-1:0];
            REG_CENTER_Z: cz_ff <= pwdata[CW-1:0];
            REG_SCALE_A2: a2_ff <= pwdata[SPMA_A2_WIDTH-1:0];
            REG_NEG_GM:   gm_ff <= pwdata[CW-1:0];
            default: ;    // drop writes past the last register
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_CENTER_X: prdata = SPMA_DATA_W'(cx_ff);
         REG_CENTER_Y: prdata = SPMA_DATA_W'(cy_ff);
         REG_CENTER_Z: prdata = SPMA_DATA_W'(cz_ff);
         REG_SCALE_A2: prdata = SPMA_DATA_W'(a2_ff);
         REG_NEG_GM:   prdata = SPMA_DATA_W'(gm_ff);
         default:      prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic vd_ff, ve_ff, vf_ff, vg_ff, vh_ff, vi_ff, vj_ff;
   logic en1, en2, en3, en4, en5, en6;
   logic end_, ene, enf, eng, enh, eni, enj;

   logic [3:0]          nw_valid, nw_ready;
   logic [3:0][MW-1:0]  nw_y, nw_m;
   logic [3:0][SIDE_W-1:0] nw_side;

   // a stage loads when empty or when its successor loads
   assign enj  = !vj_ff || rsp_chan.ready;
   assign eni  = !vi_ff || enj;
   assign enh  = !vh_ff || eni;
   assign eng  = !vg_ff || enh;
   assign enf  = !vf_ff || eng;
   assign ene  = !ve_ff || enf;
   assign end_ = !vd_ff || ene;
   assign nw_ready[3] = end_;
   assign en6  = !v6_ff || nw_ready[0];
   assign en5  = !v5_ff || en6;
   assign en4  = !v4_ff || en5;
   assign en3  = !v3_ff || en4;
   assign en2  = !v2_ff || en3;
   assign en1  = !v1_ff || en2;
   assign req_chan.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
         vd_ff <= 1'b0; ve_ff <= 1'b0; vf_ff <= 1'b0;
         vg_ff <= 1'b0; vh_ff <= 1'b0; vi_ff <= 1'b0; vj_ff <= 1'b0;
      end else begin
         if (en1)  v1_ff <= req_chan.valid;
         if (en2)  v2_ff <= v1_ff;
         if (en3)  v3_ff <= v2_ff;
         if (en4)  v4_ff <= v3_ff;
         if (en5)  v5_ff <= v4_ff;
         if (en6)  v6_ff <= v5_ff;
         if (end_) vd_ff <= nw_valid[3];
         if (ene)  ve_ff <= vd_ff;
         if (enf)  vf_ff <= ve_ff;
         if (eng)  vg_ff <= vf_ff;
         if (enh)  vh_ff <= vg_ff;
         if (eni)  vi_ff <= vh_ff;
         if (enj)  vj_ff <= vi_ff;
      end
   end

   // ---------------------------------------------------------------- datapath
   side_type side1_ff, side1_in, side2_ff, side3_ff, side3_in, side4_ff;
   side_type side5_ff, side5_in, side6_ff, sided_ff, sided_in;
   side_type sidee_ff, sidef_ff, sideg_ff, sideh_ff, sidei_ff;

   logic [2:0][SQW-1:0] sq2_ff, sq2_in;
   logic [SW-1:0]       s3_ff, s3_in, s4_ff;
   logic [BLW-1:0]      bl4_ff, bl4_in;
   logic [BLW:0]        sh5;
   logic [SW+MW-1:0]    norm5;
   logic [MW-1:0]       m5_ff, m5_in, m6_ff, y6_ff, y6_in;
   logic [MW-1:0]       yd_ff, y3e_ff, y3e_in;
   logic [MW+1:0]       yyd_ff, yyd_in;
   logic [63:0]         sqd;
   logic [65:0]         cube_e;
   logic [CW-1:0]       gmag_f;
   logic [PW-1:0]       pf_ff, pf_in;
   logic [2:0][LOW-1:0] plog_ff, plog_in;
   logic [2:0][HIW-1:0] phig_ff, phig_in;
   logic [2:0][QW-1:0]  qh_ff, qh_in;
   logic [2:0][XW-1:0]  xi_ff, xi_in;
   logic [2:0][CW-1:0]  accj_ff, accj_in;
   logic                satj_ff, satj_in;

   logic [2:0][CW-1:0]  pos_w, cen_w;
   logic [DW-1:0]       d1;
   logic                neg_j;
   logic [XW-1:0]       lim_j;
   logic [CW-1:0]       mag_j;

   assign pos_w = {req_chan.pos_z, req_chan.pos_y, req_chan.pos_x};
   assign cen_w = {cz_ff, cy_ff, cx_ff};

   always_comb begin
      // stage 1: signed offsets, split into magnitude and sign
      side1_in = '0;
      for (int i = 0; i < 3; i++) begin
         d1 = {pos_w[i][CW-1], pos_w[i]} - {cen_w[i][CW-1], cen_w[i]};
         side1_in.dn[i] = d1[DW-1];
         side1_in.dm[i] = d1[DW-1] ? (DW'(0) - d1) : d1;
      end

      // stage 2: squares
      for (int i = 0; i < 3; i++) begin
         sq2_in[i] = SQW'(side1_ff.dm[i]) * SQW'(side1_ff.dm[i]);
      end

      // stage 3: s = r2 + a2, exact
      s3_in = SW'(a2_ff) + SW'(sq2_ff[0]) + SW'(sq2_ff[1]) + SW'(sq2_ff[2]);
      side3_in      = side2_ff;
      side3_in.zero = (s3_in == '0);

      // stage 4: bit length of s
      bl4_in = '0;
      for (int i = 0; i < SW; i++) begin
         if (s3_ff[i]) bl4_in = BLW'(i + 1);
      end

      // stage 5: even-exponent normalize to a mantissa in [1,4)
      sh5      = (BLW + 1)'(bl4_ff) + (BLW + 1)'(bl4_ff[0]);
      norm5    = {s4_ff, {MW{1'b0}}} >> sh5;
      m5_in    = norm5[MW-1:0];
      side5_in = side4_ff;
      side5_in.sa = SAW'(SA_BASE + 3 * int'(sh5 >> 1));

      // stage 6: seed
      y6_in = seed_lookup(m5_ff[MW-1:MW-3]);

      // stage D/E: cube the reciprocal square root
      sqd      = 64'(nw_y[3]) * 64'(nw_y[3]);
      yyd_in   = sqd[63:30];
      sided_in = side_type'(nw_side[3]);
      cube_e   = 66'(yyd_ff) * 66'(yd_ff);
      y3e_in   = cube_e[61:30];

      // stage F: scale by |neg_gm|
      gmag_f = gm_ff[CW-1] ? (CW'(0) - gm_ff) : gm_ff;
      pf_in  = PW'(gmag_f) * PW'(y3e_ff);

      // stage G/H: per-axis product, split in two partial products
      for (int i = 0; i < 3; i++) begin
         plog_in[i] = LOW'(pf_ff[MW-1:0]) * LOW'(sidef_ff.dm[i]);
         phig_in[i] = HIW'(pf_ff[PW-1:MW]) * HIW'(sidef_ff.dm[i]);
         qh_in[i]   = QW'(plog_ff[i]) + (QW'(phig_ff[i]) << MW);
      end

      // stage I: exponent shift, truncating toward zero
      for (int i = 0; i < 3; i++) begin
         xi_in[i] = (XW'(qh_ff[i]) << LP) >> sideh_ff.sa;
      end

      // stage J: saturate and apply sign
      satj_in = sidei_ff.zero;
      for (int i = 0; i < 3; i++) begin
         neg_j = gm_ff[CW-1] ^ sidei_ff.dn[i];
         lim_j = neg_j ? (XW'(1) << (CW - 1)) : ((XW'(1) << (CW - 1)) - XW'(1));
         if (xi_ff[i] > lim_j) begin
            mag_j   = lim_j[CW-1:0];
            satj_in = 1'b1;
         end else begin
            mag_j = xi_ff[i][CW-1:0];
         end
         if (sidei_ff.zero) begin
            accj_in[i] = '0;
         end else begin
            accj_in[i] = neg_j ? (CW'(0) - mag_j) : mag_j;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) side1_ff <= side1_in;
      if (en2) begin
         side2_ff <= side1_ff;
         sq2_ff   <= sq2_in;
      end
      if (en3) begin
         side3_ff <= side3_in;
         s3_ff    <= s3_in;
      end
      if (en4) begin
         side4_ff <= side3_ff;
         s4_ff    <= s3_ff;
         bl4_ff   <= bl4_in;
      end
      if (en5) begin
         side5_ff <= side5_in;
         m5_ff    <= m5_in;
      end
      if (en6) begin
         side6_ff <= side5_ff;
         m6_ff    <= m5_ff;
         y6_ff    <= y6_in;
      end
      if (end_) begin
         sided_ff <= sided_in;
         yd_ff    <= nw_y[3];
         yyd_ff   <= yyd_in;
      end
      if (ene) begin
         sidee_ff <= sided_ff;
         y3e_ff   <= y3e_in;
      end
      if (enf) begin
         sidef_ff <= sidee_ff;
         pf_ff    <= pf_in;
      end
      if (eng) begin
         sideg_ff <= sidef_ff;
         plog_ff  <= plog_in;
         phig_ff  <= phig_in;
      end
      if (enh) begin
         sideh_ff <= sideg_ff;
         qh_ff    <= qh_in;
      end
      if (eni) begin
         sidei_ff <= sideh_ff;
         xi_ff    <= xi_in;
      end
      if (enj) begin
         accj_ff <= accj_in;
         satj_ff <= satj_in;
      end
   end

   // ---------------------------------------------------------------- Newton
   assign nw_valid[0] = v6_ff;
   assign nw_y[0]     = y6_ff;
   assign nw_m[0]     = m6_ff;
   assign nw_side[0]  = SIDE_W'(side6_ff);

   for (genvar k = 0; k < 3; k++) begin : g_newton
      spma_newton #(
         .SIDE_W (SIDE_W)
      ) u_newton (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (nw_valid[k]),
         .in_ready  (nw_ready[k]),
         .in_y      (nw_y[k]),
         .in_m      (nw_m[k]),
         .in_side   (nw_side[k]),
         .out_valid (nw_valid[k+1]),
         .out_ready (nw_ready[k+1]),
         .out_y     (nw_y[k+1]),
         .out_m     (nw_m[k+1]),
         .out_side  (nw_side[k+1])
      );
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_chan.valid     = vj_ff;
   assign rsp_chan.acc_x     = accj_ff[0];
   assign rsp_chan.acc_y     = accj_ff[1];
   assign rsp_chan.acc_z     = accj_ff[2];
   assign rsp_chan.saturated = satj_ff;

   // ---------------------------------------------------------------- checks
   // input backpressure only when every front and back stage holds a word
   `SPMA_ASSERT_IMP(a_full_on_stall, !req_chan.ready,
      v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && v6_ff && vd_ff && ve_ff &&
      vf_ff && vg_ff && vh_ff && vi_ff && vj_ff && !rsp_chan.ready,
      "input stalled with a free pipeline slot")
   // normalized mantissa must sit in [1,4)
   `SPMA_ASSERT_IMP(a_mant_norm, v5_ff && !side5_ff.zero, m5_ff[MW-1:MW-2] != 2'b00,
      "mantissa not normalized")
   // an accepted word shows up in the first stage
   `SPMA_ASSERT_NXT(a_enter, req_chan.valid && req_chan.ready, v1_ff,
      "accepted word lost at entry")

endmodule

`default_nettype wire

// File: verif/softened_point_mass_acceleration_core_tb.sv
// Self-checking bench for the softened point mass acceleration core.
// Depends on spma_pkg, spma_if and the core; drives positions, checks accelerations.
`default_nettype none

module softened_point_mass_acceleration_core_tb;
   import spma_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = SPMA_COORD_WIDTH;
   localparam int FB = SPMA_FRAC_BITS;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [CW-1:0] acc_x;
      logic [CW-1:0] acc_y;
      logic [CW-1:0] acc_z;
      logic          saturated;
   } accel_word_type;

   // Fixed-point force predictor plus the queue of predicted acceleration words.
   class accel_scoreboard;
      logic signed [CW-1:0] cen[3];
      logic [62:0] a2;
      logic signed [CW-1:0] gm;
      accel_word_type pending[$];
      int errors;

      function new();
         cen[0] = '0; cen[1] = '0; cen[2] = '0;
         a2 = SPMA_A2_RESET;
         gm = '0;
         errors = 0;
      endfunction

      function automatic logic [31:0] seed(input logic [2:0] k);
         case (k)
            3'd0, 3'd1: seed = 32'd1073741824;
            3'd2: seed = 32'd960383880;
            3'd3: seed = 32'd811672535;
            3'd4: seed = 32'd715827883;
            3'd5: seed = 32'd647490681;
            3'd6: seed = 32'd595604800;
            default: seed = 32'd554477893;
         endcase
      endfunction

      function automatic accel_word_type compute(input logic [CW-1:0] px, py, pz);
         logic [CW-1:0] pv[3];
         logic signed [CW:0] d;
         logic [CW:0] dm[3];
         logic dn[3];
         logic [127:0] s, q, p;
         logic [63:0] mfix, y, y2, t, y3, gmag, lim;
         int b, e, n, bl;
         logic gn, ng, clip, sat;
         accel_word_type r;
         logic [CW-1:0] mag;
         pv[0] = px; pv[1] = py; pv[2] = pz;
         s = {65'd0, a2};
         for (int i = 0; i < 3; i++) begin
            d = $signed(pv[i]) - $signed(cen[i]);
            dn[i] = d[CW];
            dm[i] = dn[i] ? -d : d;
            s = s + dm[i] * dm[i];
         end
         if (s == 0) begin
            r = '{acc_x: '0, acc_y: '0, acc_z: '0, saturated: 1'b1};
            return r;
         end
         b = 0;
         for (int i = 0; i < 128; i++) if (s[i]) b = i + 1;
         e = b[0] ? b - 31 : b - 32;
         mfix = (e >= 0) ? {32'd0, 32'(s >> e)} : {32'd0, 32'(s << -e)};
         y = seed(mfix[31:29]);
         for (int i = 0; i < 3; i++) begin
            y2 = (y * y) >> 30;
            t = (mfix * y2) >> 30;
            if (t > 64'hC000_0000) t = 64'hC000_0000;
            y = (y * (64'hC000_0000 - t)) >> 31;
         end
         y3 = (((y * y) >> 30) * y) >> 30;
         gn = gm[CW-1];
         gmag = gn ? 64'(-$signed({gm[CW-1], gm})) : 64'(gm);
         p = gmag * y3;
         n = 75 - 2 * FB + (3 * e) / 2;
         sat = 0;
         for (int i = 0; i < 3; i++) begin
            q = p * dm[i];
            ng = gn ^ dn[i];
            lim = ng ? (64'd1 << (CW - 1)) : (64'd1 << (CW - 1)) - 1;
            clip = 0;
            if (n >= 0) q = q >> n;
            else begin
               bl = 0;
               for (int k = 0; k < 128; k++) if (q[k]) bl = k + 1;
               if (bl - n > 127) clip = 1;
               else q = q << -n;
            end
            if (clip || q > lim) begin
               mag = lim[CW-1:0];
               sat = 1;
            end else
               mag = q[CW-1:0];
            if (ng) mag = -mag;
            case (i)
               0: r.acc_x = mag;
               1: r.acc_y = mag;
               default: r.acc_z = mag;
            endcase
         end
         r.saturated = sat;
         return r;
      endfunction

      function void note_position(input logic [CW-1:0] px, py, pz);
         pending.push_back(compute(px, py, pz));
      endfunction

      function void check_accel(input accel_word_type got);
         accel_word_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word %h", $realtime, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.acc_x !== want.acc_x) begin
            $display("%0t: acc_x exp %h got %h", $realtime, want.acc_x, got.acc_x);
            errors++;
         end
         if (got.acc_y !== want.acc_y) begin
            $display("%0t: acc_y exp %h got %h", $realtime, want.acc_y, got.acc_y);
            errors++;
         end
         if (got.acc_z !== want.acc_z) begin
            $display("%0t: acc_z exp %h got %h", $realtime, want.acc_z, got.acc_z);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $display("%0t: saturated exp %b got %b", $realtime, want.saturated,
                     got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [SPMA_ADDR_W-1:0] paddr = '0;
   logic [SPMA_DATA_W-1:0] pwdata = '0;
   logic [SPMA_DATA_W-1:0] prdata;
   logic pready;

   spma_req_if req_chan ();
   spma_rsp_if rsp_chan ();

   softened_point_mass_acceleration_core dut (
      .clock, .reset, .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   accel_scoreboard accel_sb = new();
   int send_idle_pct = 0;   // chance, per cycle, that the sender holds off
   int recv_stall_pct = 0;  // chance, per cycle, that the receiver stalls
   int quiet_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Randomize ready each cycle; check every accepted word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         accel_sb.check_accel({rsp_chan.acc_x, rsp_chan.acc_y, rsp_chan.acc_z,
                               rsp_chan.saturated});
      if (reset) rsp_chan.ready <= 0;
      else rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else if (!reset)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL softened_point_mass_acceleration_core");
         $finish;
      end
   end

   // Write one register: setup phase, access phase, then an idle phase with psel low.
   task automatic write_csr(input csr_index_type idx, input logic [63:0] value);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= SPMA_ADDR_W'(8 * idx); pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         REG_CENTER_X: accel_sb.cen[0] = value[CW-1:0];
         REG_CENTER_Y: accel_sb.cen[1] = value[CW-1:0];
         REG_CENTER_Z: accel_sb.cen[2] = value[CW-1:0];
         REG_SCALE_A2: accel_sb.a2 = value[62:0];
         default:      accel_sb.gm = value[CW-1:0];
      endcase
      @(posedge clock);
   endtask

   // Present one position word, idling first as the current mix asks; hold until taken.
   task automatic send_position(input logic [CW-1:0] px, py, pz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.pos_x <= px; req_chan.pos_y <= py; req_chan.pos_z <= pz;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      accel_sb.note_position(px, py, pz);
   endtask

   // Drop valid, wait for every predicted word, then let the pipeline settle.
   task automatic drain();
      req_chan.valid <= 0;
      while (accel_sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CW-1:0] rand_coord(input int mode);
      case (mode)
         0: rand_coord = $urandom();
         1: rand_coord = CW'($signed($urandom_range(2 << FB)) - (1 << FB));
         default: rand_coord = CW'($signed($urandom_range(32'h4000_0000)) - 32'h2000_0000);
      endcase
   endfunction

   task automatic load_setting(input int k);
      logic [63:0] a2v;
      case (k % 4)
         0: a2v = 64'd0;
         1: a2v = 64'h7FFF_FFFF_FFFF_FFFF;
         2: a2v = 64'd1 << 32;
         default: a2v = {$urandom(), $urandom()} >> $urandom_range(63);
      endcase
      write_csr(REG_CENTER_X, (k % 3 == 0) ? 64'h8000_0000 : {32'd0, $urandom()});
      write_csr(REG_CENTER_Y, (k % 3 == 1) ? 64'h7FFF_FFFF : {32'd0, rand_coord(1)});
      write_csr(REG_CENTER_Z, {32'd0, rand_coord(2)});
      write_csr(REG_SCALE_A2, a2v);
      case (k % 5)
         0: write_csr(REG_NEG_GM, 64'h8000_0000);
         1: write_csr(REG_NEG_GM, 64'h7FFF_FFFF);
         default: write_csr(REG_NEG_GM, {32'd0, $urandom()});
      endcase
   endtask

   initial begin
      int mode;
      req_chan.valid <= 0;
      req_chan.pos_x <= '0; req_chan.pos_y <= '0; req_chan.pos_z <= '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: zero denominator, reset defaults, coordinate extremes, saturation.
      write_csr(REG_SCALE_A2, 64'd0);
      write_csr(REG_NEG_GM, 64'hFFFF_0000);
      send_position('0, '0, '0);
      send_position(32'h0001_0000, '0, '0);
      send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_position(32'h0000_0001, '0, '0);
      send_position('0, 32'hFFFF_FFFF, '0);
      drain();
      write_csr(REG_CENTER_X, 64'h7FFF_FFFF);
      write_csr(REG_CENTER_Y, 64'h8000_0000);
      write_csr(REG_CENTER_Z, 64'h0000_0000);
      write_csr(REG_SCALE_A2, 64'h7FFF_FFFF_FFFF_FFFF);
      write_csr(REG_NEG_GM, 64'h8000_0000);
      send_position(32'h8000_0000, 32'h7FFF_FFFF, '0);
      send_position(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      drain();
      write_csr(REG_SCALE_A2, 64'd1);
      write_csr(REG_NEG_GM, 64'h7FFF_FFFF);
      send_position(32'h7FFF_FFFF, 32'h8000_0001, '0);
      send_position(32'h7FFF_FFFF, 32'h8000_0000, '0);
      send_position(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      drain();

      // Random phases cycling through idle mixes and register settings.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         load_setting(ph);
         for (int i = 0; i < 94; i++) begin
            mode = $urandom_range(2);
            if (i == 47) drain();  // hold off until the pipeline is empty
            send_position(rand_coord(mode), rand_coord(mode), rand_coord(mode));
         end
         drain();
      end

      if (accel_sb.errors == 0)
         $display("PASS softened_point_mass_acceleration_core");
      else
         $display("FAIL softened_point_mass_acceleration_core");
      $finish;
   end

endmodule

`default_nettype wire
